[rtl/visual_servo_stepper_profile_core_assert.svh]
// Assertion macros for the visual servo stepper profile core.
// Taken in by the RTL files that carry concurrent checks.
`ifndef VISUAL_SERVO_STEPPER_PROFILE_CORE_ASSERT_SVH
`define VISUAL_SERVO_STEPPER_PROFILE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VSSP_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VSSP_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vssp_pkg.sv]
// Package for the visual servo stepper profile core: constants, state and
// register codes, control structs and the exp2 factor table. No dependencies.
`default_nettype none

package vssp_pkg;

	localparam int unsigned DIV_W = 40;
	localparam int unsigned REM_W = 20;

	localparam logic [15:0] Q14_ONE  = 16'd16384;
	localparam logic [16:0] Q14_TWO  = 17'd32768;
	localparam logic [15:0] K_POINT3 = 16'd4915;
	localparam logic [15:0] K_POINT7 = 16'd11469;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ZONE,
		ST_SQ_DIV,
		ST_SQ_ROOT,
		ST_SQ_MUL,
		ST_UP_DIV,
		ST_STEP_A,
		ST_STEP_B,
		ST_RQ_DIV,
		ST_LOG_SQ,
		ST_LOG_MUL,
		ST_EXP_MUL,
		ST_RATE_MUL,
		ST_PER_DIV,
		ST_DONE
	} vssp_state_t;

	typedef enum logic [2:0] {
		REG_DEADZONE,
		REG_DEADZONE_WIDE,
		REG_DECEL_START,
		REG_MAX_PIXEL_DIFF,
		REG_PIXEL_TO_STEP,
		REG_MIN_SPEED,
		REG_MAX_SPEED,
		REG_DIR_CW_LEVEL
	} vssp_reg_t;

	// Command to the divide / square-root unit
	typedef struct packed {
		logic       start;
		logic       sqrt_mode;
		logic [5:0] iters;
	} vssp_dv_ctrl_t;

	// Status back from the divide / square-root unit
	typedef struct packed {
		logic busy;
		logic done;
	} vssp_dv_stat_t;

	typedef logic [31:0] exp_tab_t [16];

	// Floor integer square root, elaboration use only
	function automatic logic [63:0] isqrt_c(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = xin;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Factors 2^(-2^-i) in Q30, i = 1..16, by repeated square roots
	function automatic exp_tab_t exp_table();
		exp_tab_t t;
		logic [63:0] c;
		c = isqrt_c(64'd1 << 59);
		for (int i = 0; i < 16; i++) begin
			t[i] = c[31:0];
			c = isqrt_c(c << 30);
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = exp_table();

endpackage

`default_nettype wire

[rtl/visual_servo_stepper_profile_core.sv]
// The input is stalled from the accepting edge until the sequencer is back in idle
// after the registered result word is formed, so an item is finished before the
// next is taken; a stalled result word holds the input off too.
// The time goes to the bit-serial divide/root unit (one bit per cycle, up to 40
// bits per divide) and to the steps of the shared registered multiplier.
// Reset: registers to defaults, steps 0, rate 0, scale 1.0, motion flag clear.
`default_nettype none

`include "visual_servo_stepper_profile_core_assert.svh"

module visual_servo_stepper_profile_core import vssp_pkg::*; #(
	parameter int unsigned MAX_STEP_COUNT = 4096,
	parameter int unsigned CLOCK_HZ       = 550000000,
	parameter int unsigned POW_TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [11:0] pixel_error,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [29:0]        pwm_compare,
	output logic               compare_valid,
	output logic [29:0]        reload_period,
	output logic               reload_valid,
	output logic               dir_level,
	output logic               moving,
	output logic signed [13:0] steps_left,
	output logic [15:0]        speed_now,
	output logic [15:0]        accel_scale
);

	localparam logic [DIV_W-1:0]  CLK_DIVIDEND = DIV_W'(CLOCK_HZ);
	localparam logic [13:0]       STEP_LIMIT   = 14'(MAX_STEP_COUNT);
	localparam logic signed [14:0] STEP_LIM_S  = 15'(MAX_STEP_COUNT);
	localparam logic [DIV_W-1:0]  RQ_ONE       = DIV_W'(1) << POW_TABLE_BITS;
	localparam logic [5:0]        RQ_ITERS     = 6'(12 + POW_TABLE_BITS);
	localparam logic [20:0]       LOG_FULL     = 21'(POW_TABLE_BITS) << 16;

	// Configuration registers
	logic [10:0] deadzone_q;
	logic [10:0] deadzone_wide_q;
	logic [10:0] decel_start_q;
	logic [10:0] max_pixel_diff_q;
	logic [15:0] pixel_to_step_q;
	logic [15:0] min_speed_q;
	logic [15:0] max_speed_q;
	logic        dir_cw_level_q;

	// Architectural state
	logic signed [13:0] pend_q;
	logic [15:0]        rate_q;
	logic [15:0]        scale_q;
	logic               moving_q;

	// Sequencer
	vssp_state_t state_q, state_d;
	logic        ph_q;
	logic [3:0]  it_q;
	logic        loop_st;

	// Work registers
	logic               type_q;
	logic               dz_q;
	logic               neg_q;
	logic [11:0]        a_q;
	logic signed [13:0] pend_w_q;
	logic [15:0]        rate_w_q;
	logic [15:0]        scale_w_q;
	logic [31:0]        acc_q;
	logic [31:0]        y_q;
	logic [15:0]        frac_q;
	logic [3:0]         m_q;
	logic [20:0]        d_q;
	logic [30:0]        v_q;
	logic [16:0]        p_q;
	logic [29:0]        per_q;

	// Output word
	logic               out_valid_q;
	logic [29:0]        cmp_o_q;
	logic               cmp_v_o_q;
	logic [29:0]        rel_o_q;
	logic               rel_v_o_q;
	logic               dir_o_q;
	logic               mov_o_q;
	logic signed [13:0] steps_o_q;
	logic [15:0]        speed_o_q;
	logic [15:0]        scale_o_q;

	// Shared units
	vssp_dv_ctrl_t    dv_ctrl;
	vssp_dv_stat_t    dv_stat;
	logic [DIV_W-1:0] dv_operand;
	logic [15:0]      dv_divisor;
	logic [DIV_W-1:0] quo;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      mul_p;

	logic        accept;
	logic        fire;
	logic        div_st;
	logic [15:0] e_w;
	logic [15:0] rate_div;
	logic [3:0]  rq_msb;
	logic [31:0] y_init;
	logic [31:0] sq_t;
	logic [30:0] new_v;
	logic [41:0] mag_raw;
	logic [13:0] mag_c;
	logic [4:0]  k_log;
	logic [4:0]  k_d;
	logic [15:0] d_frac;
	logic [11:0] a_in;

	logic signed [13:0] fin_pend;
	logic               fin_moving;
	logic               fin_dir;
	logic [29:0]        fin_cmp;
	logic [29:0]        fin_rel;
	logic               fin_rel_v;

	vssp_divsqrt u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (dv_ctrl),
		.operand (dv_operand),
		.divisor (dv_divisor),
		.stat    (dv_stat),
		.result  (quo)
	);

	vssp_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	assign accept  = in_valid && !in_stall;
	assign fire    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign loop_st = (state_q == ST_LOG_SQ) || (state_q == ST_EXP_MUL);
	assign e_w     = 16'(Q14_TWO - {1'b0, scale_w_q});
	assign rate_div = (rate_w_q == 16'd0) ? 16'd1 : rate_w_q;
	assign a_in    = pixel_error[11] ? 12'(13'd4096 - {1'b0, $unsigned(pixel_error)})
		: $unsigned(pixel_error);
	assign sq_t    = mul_p[61:30];
	assign new_v   = mul_p[60:30];
	assign mag_raw = mul_p[63:22];
	assign mag_c   = (mag_raw > 42'(STEP_LIMIT)) ? STEP_LIMIT : mag_raw[13:0];
	assign k_log   = mul_p[34:30];
	assign k_d     = d_q[20:16];
	assign d_frac  = d_q[15:0];

	// Find the leading one of the speed ratio
	always_comb begin
		rq_msb = 4'd0;
		for (int i = 0; i < 12; i++) begin
			if (quo[i]) begin
				rq_msb = 4'(i);
			end
		end
	end
	assign y_init = 32'(quo[11:0]) << (5'd30 - {1'b0, rq_msb});

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q       <= 11'd5;
			deadzone_wide_q  <= 11'd5;
			decel_start_q    <= 11'd96;
			max_pixel_diff_q <= 11'd320;
			pixel_to_step_q  <= 16'd256;
			min_speed_q      <= 16'd100;
			max_speed_q      <= 16'd2000;
			dir_cw_level_q   <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (vssp_reg_t'(cfg_index))
				REG_DEADZONE:       deadzone_q       <= cfg_data[10:0];
				REG_DEADZONE_WIDE:  deadzone_wide_q  <= cfg_data[10:0];
				REG_DECEL_START:    decel_start_q    <= cfg_data[10:0];
				REG_MAX_PIXEL_DIFF: max_pixel_diff_q <= cfg_data[10:0];
				REG_PIXEL_TO_STEP:  pixel_to_step_q  <= cfg_data;
				REG_MIN_SPEED:      min_speed_q      <= cfg_data;
				REG_MAX_SPEED:      max_speed_q      <= cfg_data;
				REG_DIR_CW_LEVEL:   dir_cw_level_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!req_type) begin
						state_d = ST_ZONE;
					end else if (pend_q != 14'sd0) begin
						state_d = ST_PER_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ZONE: begin
				if (a_q < {1'b0, deadzone_q}) begin
					state_d = ST_DONE;
				end else if (a_q <= {1'b0, deadzone_wide_q}) begin
					state_d = ST_STEP_A;
				end else if (a_q <= {1'b0, decel_start_q}) begin
					state_d = ST_SQ_DIV;
				end else if (max_pixel_diff_q <= decel_start_q) begin
					state_d = ST_STEP_A;
				end else begin
					state_d = ST_UP_DIV;
				end
			end
			ST_SQ_DIV:  if (ph_q && dv_stat.done) state_d = ST_SQ_ROOT;
			ST_SQ_ROOT: if (ph_q && dv_stat.done) state_d = ST_SQ_MUL;
			ST_SQ_MUL:  if (ph_q) state_d = ST_STEP_A;
			ST_UP_DIV:  if (ph_q && dv_stat.done) state_d = ST_STEP_A;
			ST_STEP_A:  if (ph_q) state_d = ST_STEP_B;
			ST_STEP_B: begin
				if (ph_q) begin
					state_d = (max_pixel_diff_q == 11'd0) ? ST_RATE_MUL : ST_RQ_DIV;
				end
			end
			ST_RQ_DIV: begin
				if (ph_q && dv_stat.done) begin
					if (quo >= RQ_ONE || quo == '0) begin
						state_d = ST_RATE_MUL;
					end else begin
						state_d = ST_LOG_SQ;
					end
				end
			end
			ST_LOG_SQ:  if (ph_q && it_q == 4'd15) state_d = ST_LOG_MUL;
			ST_LOG_MUL: begin
				if (ph_q) begin
					state_d = (k_log > 5'd16) ? ST_RATE_MUL : ST_EXP_MUL;
				end
			end
			ST_EXP_MUL:  if (ph_q && it_q == 4'd15) state_d = ST_RATE_MUL;
			ST_RATE_MUL: if (ph_q) state_d = ST_PER_DIV;
			ST_PER_DIV:  if (ph_q && dv_stat.done) state_d = ST_DONE;
			ST_DONE:     if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Unit commands and operand selection
	always_comb begin
		div_st            = 1'b0;
		dv_operand        = '0;
		dv_divisor        = 16'd0;
		dv_ctrl.sqrt_mode = 1'b0;
		dv_ctrl.iters     = 6'd40;
		mul_a             = 32'd0;
		mul_b             = 32'd0;
		in_stall          = (state_q != ST_IDLE);
		unique case (state_q)
			ST_SQ_DIV: begin
				div_st     = 1'b1;
				dv_operand = DIV_W'({a_q - {1'b0, deadzone_wide_q}, 28'd0});
				dv_divisor = {5'd0, decel_start_q - deadzone_wide_q};
			end
			ST_SQ_ROOT: begin
				div_st            = 1'b1;
				dv_operand        = DIV_W'(acc_q);
				dv_ctrl.sqrt_mode = 1'b1;
				dv_ctrl.iters     = 6'd15;
			end
			ST_UP_DIV: begin
				div_st        = 1'b1;
				dv_operand    = DIV_W'({a_q - {1'b0, decel_start_q}, 14'd0});
				dv_divisor    = {5'd0, max_pixel_diff_q - decel_start_q};
				dv_ctrl.iters = 6'd26;
			end
			ST_RQ_DIV: begin
				div_st        = 1'b1;
				dv_operand    = DIV_W'(a_q) << POW_TABLE_BITS;
				dv_divisor    = {5'd0, max_pixel_diff_q};
				dv_ctrl.iters = RQ_ITERS;
			end
			ST_PER_DIV: begin
				div_st        = 1'b1;
				dv_operand    = CLK_DIVIDEND;
				dv_divisor    = rate_div;
				dv_ctrl.iters = 6'd30;
			end
			ST_SQ_MUL: begin
				mul_a = 32'(K_POINT7);
				mul_b = acc_q;
			end
			ST_STEP_A: begin
				mul_a = 32'(a_q);
				mul_b = 32'(pixel_to_step_q);
			end
			ST_STEP_B: begin
				mul_a = acc_q;
				mul_b = 32'(scale_w_q);
			end
			ST_LOG_SQ: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			ST_LOG_MUL: begin
				mul_a = 32'(LOG_FULL - {1'b0, m_q, frac_q});
				mul_b = 32'(e_w);
			end
			ST_EXP_MUL: begin
				mul_a = 32'(v_q);
				mul_b = d_frac[4'd15 - it_q] ? EXP_TAB[it_q] : 32'd1 << 30;
			end
			ST_RATE_MUL: begin
				mul_a = 32'(max_speed_q - min_speed_q);
				mul_b = 32'(p_q);
			end
			default: ;
		endcase
		dv_ctrl.start = div_st && !ph_q;
	end

	// Advance the sequencer phase and loop count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			it_q    <= 4'd0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				ph_q <= 1'b0;
				it_q <= 4'd0;
			end else if (loop_st) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					it_q <= it_q + 4'd1;
				end
			end else begin
				ph_q <= 1'b1;
			end
		end
	end

	// Work datapath
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (accept) begin
					type_q    <= req_type;
					neg_q     <= pixel_error[11];
					a_q       <= a_in;
					dz_q      <= 1'b0;
					pend_w_q  <= pend_q;
					rate_w_q  <= rate_q;
					scale_w_q <= scale_q;
				end
			end
			ST_ZONE: begin
				if (a_q < {1'b0, deadzone_q}) begin
					dz_q     <= 1'b1;
					pend_w_q <= 14'sd0;
				end else if (a_q <= {1'b0, deadzone_wide_q}) begin
					scale_w_q <= K_POINT3;
				end else if (a_q > {1'b0, decel_start_q}
					&& max_pixel_diff_q <= decel_start_q) begin
					scale_w_q <= 16'(Q14_TWO);
				end
			end
			ST_SQ_DIV, ST_SQ_ROOT: begin
				if (ph_q && dv_stat.done) begin
					acc_q <= quo[31:0];
				end
			end
			ST_SQ_MUL: begin
				if (ph_q) begin
					scale_w_q <= K_POINT3 + 16'((mul_p[27:0] + 28'd8192) >> 14);
				end
			end
			ST_UP_DIV: begin
				if (ph_q && dv_stat.done) begin
					scale_w_q <= Q14_ONE + ((quo > DIV_W'(Q14_ONE)) ? Q14_ONE : quo[15:0]);
				end
			end
			ST_STEP_A: begin
				if (ph_q) begin
					acc_q <= mul_p[31:0];
				end
			end
			ST_STEP_B: begin
				if (ph_q) begin
					pend_w_q <= neg_q ? $signed(14'd0 - mag_c) : $signed(mag_c);
					if (max_pixel_diff_q == 11'd0) begin
						p_q <= 17'd65536;
					end
				end
			end
			ST_RQ_DIV: begin
				if (ph_q && dv_stat.done) begin
					if (quo >= RQ_ONE) begin
						p_q <= 17'd65536;
					end else if (quo == '0) begin
						p_q <= (e_w == 16'd0) ? 17'd65536 : 17'd0;
					end else begin
						m_q    <= rq_msb;
						y_q    <= y_init;
						frac_q <= 16'd0;
					end
				end
			end
			ST_LOG_SQ: begin
				if (ph_q) begin
					if (sq_t[31]) begin
						y_q <= sq_t >> 1;
						frac_q[4'd15 - it_q] <= 1'b1;
					end else begin
						y_q <= sq_t;
					end
				end
			end
			ST_LOG_MUL: begin
				if (ph_q) begin
					d_q <= mul_p[34:14];
					if (k_log > 5'd16) begin
						p_q <= 17'd0;
					end else begin
						v_q <= 31'd1 << 30;
					end
				end
			end
			ST_EXP_MUL: begin
				if (ph_q) begin
					v_q <= new_v;
					if (it_q == 4'd15) begin
						p_q <= 17'(new_v >> (5'd14 + k_d));
					end
				end
			end
			ST_RATE_MUL: begin
				if (ph_q) begin
					rate_w_q <= (max_speed_q > min_speed_q)
						? min_speed_q + 16'(mul_p[32:16]) : max_speed_q;
				end
			end
			ST_PER_DIV: begin
				if (ph_q && dv_stat.done) begin
					per_q <= quo[29:0];
				end
			end
			default: ;
		endcase
	end

	// Form the result word and the state after this item
	always_comb begin
		fin_pend   = pend_w_q;
		fin_moving = moving_q;
		fin_dir    = 1'b0;
		fin_cmp    = 30'd0;
		fin_rel    = 30'd0;
		fin_rel_v  = 1'b0;
		if (type_q) begin
			if (pend_w_q != 14'sd0) begin
				fin_pend   = (pend_w_q > 14'sd0) ? pend_w_q - 14'sd1 : pend_w_q + 14'sd1;
				fin_moving = (fin_pend != 14'sd0);
				fin_dir    = (pend_w_q > 14'sd0) ? dir_cw_level_q : !dir_cw_level_q;
				fin_cmp    = per_q >> 1;
			end else begin
				fin_moving = 1'b0;
			end
		end else if (!dz_q) begin
			fin_moving = 1'b1;
			fin_rel    = per_q - 30'd1;
			fin_rel_v  = 1'b1;
		end
	end

	// Commit state and hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 14'sd0;
			rate_q      <= 16'd0;
			scale_q     <= Q14_ONE;
			moving_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				pend_q      <= fin_pend;
				rate_q      <= rate_w_q;
				scale_q     <= scale_w_q;
				moving_q    <= fin_moving;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cmp_o_q   <= fin_cmp;
			cmp_v_o_q <= type_q;
			rel_o_q   <= fin_rel;
			rel_v_o_q <= fin_rel_v;
			dir_o_q   <= fin_dir;
			mov_o_q   <= fin_moving;
			steps_o_q <= fin_pend;
			speed_o_q <= rate_w_q;
			scale_o_q <= scale_w_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_compare   = cmp_o_q;
	assign compare_valid = cmp_v_o_q;
	assign reload_period = rel_o_q;
	assign reload_valid  = rel_v_o_q;
	assign dir_level     = dir_o_q;
	assign moving        = mov_o_q;
	assign steps_left    = steps_o_q;
	assign speed_now     = speed_o_q;
	assign accel_scale   = scale_o_q;

	`VSSP_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, in_stall, "input side not busy after accept")
	`VSSP_ASSERT_IMP(a_one_kind, clk, arst_n, out_valid, !(compare_valid && reload_valid), "tick and reload in one word")
	`VSSP_ASSERT_IMP(a_steps_range, clk, arst_n, out_valid, (steps_left <= STEP_LIM_S) && (steps_left >= -STEP_LIM_S), "step count beyond limit")
	`VSSP_ASSERT_IMP(a_reload_moving, clk, arst_n, out_valid && reload_valid, moving, "reload without motion")
	`VSSP_ASSERT_IMP(a_start_idle, clk, arst_n, dv_ctrl.start, !dv_stat.busy, "divider started while busy")

endmodule

`default_nettype wire

[rtl/vssp_divsqrt.sv]
// Shared bit-serial divide and square-root unit: one quotient or root bit
// per cycle through a single compare-subtract. Depends on vssp_pkg.
`default_nettype none

module vssp_divsqrt import vssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  vssp_dv_ctrl_t     ctrl,
	input  logic [DIV_W-1:0]  operand,
	input  logic [15:0]       divisor,
	output vssp_dv_stat_t     stat,
	output logic [DIV_W-1:0]  result
);

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic             mode_q;
	logic [DIV_W-1:0] x_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [15:0]      den_q;

	logic [6:0]       used_bits;
	logic [6:0]       align_sh;
	logic [REM_W-1:0] part;
	logic [REM_W-1:0] trial;
	logic             ge;

	// Left-align the operand so its top bit or bit pair is consumed first
	assign used_bits = ctrl.sqrt_mode ? {ctrl.iters, 1'b0} : {1'b0, ctrl.iters};
	assign align_sh  = 7'(DIV_W) - used_bits;

	// Bring down the next bit (divide) or bit pair (root) and try a subtract
	always_comb begin
		if (mode_q) begin
			part  = {rem_q[REM_W-3:0], x_q[DIV_W-1:DIV_W-2]};
			trial = {quo_q[REM_W-3:0], 2'b01};
		end else begin
			part  = {rem_q[REM_W-2:0], x_q[DIV_W-1]};
			trial = {(REM_W-16)'(0), den_q};
		end
		ge = part >= trial;
	end

	// Sequence the iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctrl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift operand, remainder and result
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			mode_q <= ctrl.sqrt_mode;
			x_q    <= operand << align_sh;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			x_q   <= mode_q ? (x_q << 2) : (x_q << 1);
			rem_q <= ge ? (part - trial) : part;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = quo_q;

endmodule

`default_nettype wire

[rtl/vssp_mul.sv]
// Registered 32x32 unsigned multiplier shared by all product steps.
// Depends on nothing but the clock; the product shows in the cycle after its operands.
`default_nettype none

module vssp_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire
